// ===== sv/log_status_code_histogram_defines.svh =====
// ----------------------------------------------------------------------------
// log_status_code_histogram_defines
// assertion macros used by the checker file
// ----------------------------------------------------------------------------
`ifndef LOG_STATUS_CODE_HISTOGRAM_DEFINES_SVH
`define LOG_STATUS_CODE_HISTOGRAM_DEFINES_SVH

// clocked property, off while reset is asserted
`define LSCH_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// clocked implication, off while reset is asserted
`define LSCH_ASSERT_IMP(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

`endif

// ===== sv/lsch_pkg.sv =====
// ----------------------------------------------------------------------------
// lsch_pkg
// shared types and constants of the status code histogram
// ----------------------------------------------------------------------------
package lsch_pkg;

    localparam int CODE_LIMIT_DEF = 600;
    localparam int COUNT_BITS_DEF = 31;

    localparam int ACT_BITS    = 2;
    localparam int BYTE_BITS   = 8;
    localparam int CODE_BITS   = 10;
    localparam int OCC_BITS    = 31;
    localparam int S_DATA_BITS = 24;
    localparam int M_DATA_BITS = 48;

    localparam int LOW_CODE   = 100;
    localparam int NUM_SAT    = 1000;
    localparam int OUTQ_DEPTH = 3;

    localparam logic [BYTE_BITS-1:0] QUOTE_BYTE = 8'd34;
    localparam logic [BYTE_BITS-1:0] LINE_END   = 8'd10;
    localparam logic [BYTE_BITS-1:0] PLUS_BYTE  = 8'd43;
    localparam logic [BYTE_BITS-1:0] MINUS_BYTE = 8'd45;
    localparam logic [BYTE_BITS-1:0] ZERO_BYTE  = 8'd48;
    localparam logic [BYTE_BITS-1:0] NINE_BYTE  = 8'd57;

    localparam logic [OCC_BITS-1:0] OCC_MAX = '1;

    typedef enum logic [ACT_BITS-1:0] {
        ACT_BYTE  = 2'd0,
        ACT_FLUSH = 2'd1,
        ACT_READ  = 2'd2
    } action_t;

    typedef enum logic {
        OP_INC  = 1'b0,
        OP_READ = 1'b1
    } op_kind_t;

    // counter access from the parser
    typedef struct packed {
        logic                 valid;
        op_kind_t             kind;
        logic [CODE_BITS-1:0] code;
        logic                 in_range;
    } op_t;

    // one read result
    typedef struct packed {
        logic                 valid;
        logic [CODE_BITS-1:0] code;
        logic [OCC_BITS-1:0]  occ;
    } res_t;

endpackage

// ===== sv/lsch_ram.sv =====
// ----------------------------------------------------------------------------
// lsch_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module lsch_ram #(
    parameter int WIDTH     = 8,
    parameter int DEPTH     = 16,
    parameter int ADDR_BITS = $clog2(DEPTH)
) (
    input  logic                 clk,
    input  logic                 wr_en,
    input  logic [ADDR_BITS-1:0] wr_addr,
    input  logic [WIDTH-1:0]     wr_data,
    input  logic [ADDR_BITS-1:0] rd_addr,
    output logic [WIDTH-1:0]     rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== sv/lsch_parse.sv =====
// ----------------------------------------------------------------------------
// lsch_parse
// per line parser: quotes, whitespace, sign and digits of the status code
// ----------------------------------------------------------------------------
module lsch_parse
    import lsch_pkg::*;
#(
    parameter int CODE_LIMIT = CODE_LIMIT_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 accept,
    input  logic [ACT_BITS-1:0]  action,
    input  logic [BYTE_BITS-1:0] byte_value,
    input  logic [CODE_BITS-1:0] query_code,
    output op_t                  op
);

    typedef enum logic [5:0] {
        PH_SEEK1  = 6'b000001,
        PH_SEEK2  = 6'b000010,
        PH_SPACE  = 6'b000100,
        PH_SIGN   = 6'b001000,
        PH_DIGITS = 6'b010000,
        PH_DONE   = 6'b100000
    } phase_t;

    localparam logic [CODE_BITS-1:0] LIMIT = CODE_BITS'(CODE_LIMIT);
    localparam logic [CODE_BITS-1:0] LOW   = CODE_BITS'(LOW_CODE);

    phase_t               phase_reg, phase_next;
    logic [CODE_BITS-1:0] num_reg, num_next;
    logic                 neg_reg, neg_next;

    logic                 is_digit;
    logic                 is_space;
    logic [3:0]           digit;
    logic [13:0]          prod;
    logic [CODE_BITS-1:0] num_dig;
    logic                 line_end;

    assign is_digit = (byte_value >= ZERO_BYTE) && (byte_value <= NINE_BYTE);
    assign is_space = (byte_value == 8'd32) || (byte_value == 8'd9) ||
                      (byte_value == 8'd11) || (byte_value == 8'd12) ||
                      (byte_value == 8'd13);
    assign digit    = 4'(byte_value - ZERO_BYTE);

    // value * 10 + digit, saturating
    assign prod    = 14'({num_reg, 3'b000}) + 14'({num_reg, 1'b0}) + 14'(digit);
    assign num_dig = (prod > 14'(NUM_SAT)) ? CODE_BITS'(NUM_SAT) : prod[CODE_BITS-1:0];

    assign line_end = (action == ACT_FLUSH) ||
                      ((action == ACT_BYTE) && (byte_value == LINE_END));

    always_comb
    begin
        phase_next  = phase_reg;
        num_next    = num_reg;
        neg_next    = neg_reg;
        op.valid    = 1'b0;
        op.kind     = OP_INC;
        op.code     = num_reg;
        op.in_range = 1'b1;
        if (accept)
        begin
            if (line_end)
            begin
                op.valid   = !neg_reg && (num_reg >= LOW) && (num_reg < LIMIT);
                phase_next = PH_SEEK1;
                num_next   = '0;
                neg_next   = 1'b0;
            end
            else if (action == ACT_READ)
            begin
                op.valid    = 1'b1;
                op.kind     = OP_READ;
                op.code     = query_code;
                op.in_range = (query_code >= LOW) && (query_code < LIMIT);
            end
            else if (action == ACT_BYTE)
            begin
                case (phase_reg)
                    PH_SEEK1:
                    begin
                        if (byte_value == QUOTE_BYTE)
                        begin
                            phase_next = PH_SEEK2;
                        end
                    end
                    PH_SEEK2:
                    begin
                        if (byte_value == QUOTE_BYTE)
                        begin
                            phase_next = PH_SPACE;
                        end
                    end
                    PH_SPACE:
                    begin
                        if (is_space)
                        begin
                            phase_next = PH_SPACE;
                        end
                        else if ((byte_value == PLUS_BYTE) || (byte_value == MINUS_BYTE))
                        begin
                            neg_next   = (byte_value == MINUS_BYTE);
                            phase_next = PH_SIGN;
                        end
                        else if (is_digit)
                        begin
                            num_next   = num_dig;
                            phase_next = PH_DIGITS;
                        end
                        else
                        begin
                            phase_next = PH_DONE;
                        end
                    end
                    PH_SIGN, PH_DIGITS:
                    begin
                        if (is_digit)
                        begin
                            num_next   = num_dig;
                            phase_next = PH_DIGITS;
                        end
                        else
                        begin
                            phase_next = PH_DONE;
                        end
                    end
                    default:
                    begin
                        phase_next = phase_reg;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_SEEK1;
            num_reg   <= '0;
            neg_reg   <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            num_reg   <= num_next;
            neg_reg   <= neg_next;
        end
    end

endmodule

// ===== sv/lsch_update.sv =====
// ----------------------------------------------------------------------------
// lsch_update
// counter memory with clearing sweep, read-modify-write and forwarding
// ----------------------------------------------------------------------------
module lsch_update
    import lsch_pkg::*;
#(
    parameter int CODE_LIMIT = CODE_LIMIT_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic clk,
    input  logic rst_n,
    input  op_t  op,
    output logic clearing,
    output logic read_pend,
    output res_t res
);

    localparam int SLOTS = CODE_LIMIT - LOW_CODE;
    localparam int AW    = $clog2(SLOTS);
    localparam int WIDE  = (COUNT_BITS > OCC_BITS) ? COUNT_BITS : OCC_BITS;

    logic                  clear_reg, clear_next;
    logic [AW-1:0]         clr_idx_reg, clr_idx_next;

    logic                  s1_valid_reg;
    op_kind_t              s1_kind_reg;
    logic [CODE_BITS-1:0]  s1_code_reg;
    logic                  s1_range_reg;
    logic [AW-1:0]         s1_addr_reg;

    logic                  fwd_valid_reg;
    logic [AW-1:0]         fwd_addr_reg;
    logic [COUNT_BITS-1:0] fwd_data_reg;

    logic [AW-1:0]         rd_addr;
    logic [COUNT_BITS-1:0] rd_data;
    logic [COUNT_BITS-1:0] cur;
    logic [COUNT_BITS-1:0] inc;
    logic [WIDE-1:0]       cur_wide;
    logic                  wr_en;
    logic [AW-1:0]         wr_addr;
    logic [COUNT_BITS-1:0] wr_data;

    assign rd_addr = op.in_range ? AW'(op.code - CODE_BITS'(LOW_CODE)) : '0;

    // latest write wins over the stale ram word
    assign cur = (fwd_valid_reg && (fwd_addr_reg == s1_addr_reg)) ? fwd_data_reg : rd_data;
    assign inc = (cur == '1) ? cur : cur + COUNT_BITS'(1);

    assign wr_en   = clear_reg || (s1_valid_reg && (s1_kind_reg == OP_INC));
    assign wr_addr = clear_reg ? clr_idx_reg : s1_addr_reg;
    assign wr_data = clear_reg ? '0 : inc;

    assign cur_wide  = WIDE'(cur);
    assign res.valid = s1_valid_reg && (s1_kind_reg == OP_READ);
    assign res.code  = s1_code_reg;
    assign res.occ   = !s1_range_reg ? '0 :
                       (cur_wide > WIDE'(OCC_MAX)) ? OCC_MAX : cur_wide[OCC_BITS-1:0];

    assign read_pend = res.valid;
    assign clearing  = clear_reg;

    always_comb
    begin
        clear_next   = clear_reg;
        clr_idx_next = clr_idx_reg;
        if (clear_reg)
        begin
            clr_idx_next = clr_idx_reg + AW'(1);
            if (clr_idx_reg == AW'(SLOTS - 1))
            begin
                clear_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_reg     <= 1'b1;
            clr_idx_reg   <= '0;
            s1_valid_reg  <= 1'b0;
            fwd_valid_reg <= 1'b0;
        end
        else
        begin
            clear_reg     <= clear_next;
            clr_idx_reg   <= clr_idx_next;
            s1_valid_reg  <= op.valid;
            fwd_valid_reg <= wr_en;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_kind_reg  <= op.kind;
        s1_code_reg  <= op.code;
        s1_range_reg <= op.in_range;
        s1_addr_reg  <= rd_addr;
        fwd_addr_reg <= wr_addr;
        fwd_data_reg <= wr_data;
    end

    lsch_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (SLOTS)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

endmodule

// ===== sv/lsch_outq.sv =====
// ----------------------------------------------------------------------------
// lsch_outq
// small result queue in front of the output stream
// ----------------------------------------------------------------------------
module lsch_outq
    import lsch_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  res_t                   res,
    input  logic                   pop,
    output logic                   head_valid,
    output logic [CODE_BITS-1:0]   head_code,
    output logic [OCC_BITS-1:0]    head_occ,
    output logic [1:0]             count
);

    typedef struct packed {
        logic [CODE_BITS-1:0] code;
        logic [OCC_BITS-1:0]  occ;
    } entry_t;

    entry_t     entry_reg [OUTQ_DEPTH];
    logic [1:0] wr_ptr_reg, wr_ptr_next;
    logic [1:0] rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       do_pop;

    assign do_pop = pop && (count_reg != 2'd0);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (res.valid)
        begin
            wr_ptr_next = (wr_ptr_reg == 2'(OUTQ_DEPTH - 1)) ? 2'd0 : wr_ptr_reg + 2'd1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == 2'(OUTQ_DEPTH - 1)) ? 2'd0 : rd_ptr_reg + 2'd1;
        end
        case ({res.valid, do_pop})
            2'b10:   count_next = count_reg + 2'd1;
            2'b01:   count_next = count_reg - 2'd1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res.valid)
        begin
            entry_reg[wr_ptr_reg] <= '{code: res.code, occ: res.occ};
        end
    end

    assign head_valid = (count_reg != 2'd0);
    assign head_code  = entry_reg[rd_ptr_reg].code;
    assign head_occ   = entry_reg[rd_ptr_reg].occ;
    assign count      = count_reg;

endmodule

// ===== sv/log_status_code_histogram.sv =====
// ----------------------------------------------------------------------------
// log_status_code_histogram
// status code histogram over a stream of log text bytes
// ----------------------------------------------------------------------------
// One input word is taken per clock cycle, whatever its action: a text byte,
// a flush that ends the current line, or a read of one code's count. Each
// line is parsed as it streams by; at its end the code found after the
// second double quote bumps one counter in an on-chip ram by read, increment
// and write back, with the last write forwarded so that lines ending on
// consecutive cycles with the same code count correctly. A read's result
// word is registered in the update stage and then in a three-entry result
// queue that keeps the input flowing while the output side stalls; input
// ready drops only while the ram is swept or when that queue could
// overflow. After reset the ram is swept to zero, one entry per cycle, over all
// CODE_LIMIT - 100 entries (500 by default), accepting no input word meanwhile.
// ----------------------------------------------------------------------------
module log_status_code_histogram
    import lsch_pkg::*;
#(
    parameter int CODE_LIMIT = CODE_LIMIT_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,

    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // byte_value [7:0], query_code [17:8], zero [23:18]
    input  logic [S_DATA_BITS-1:0] s_axis_tdata,
    // action [1:0]
    input  logic [ACT_BITS-1:0]    s_axis_tuser,

    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // reported_code [9:0], occurrences [40:10], zero [47:41]
    output logic [M_DATA_BITS-1:0] m_axis_tdata
);

    logic                 accept;
    op_t                  op;
    res_t                 res;
    logic                 clearing;
    logic                 read_pend;
    logic [1:0]           q_count;
    logic [CODE_BITS-1:0] head_code;
    logic [OCC_BITS-1:0]  head_occ;
    logic [2:0]           credit_used;

    // room for every result already on its way plus one more
    assign credit_used   = 3'(q_count) + 3'(read_pend);
    assign s_axis_tready = !clearing && (credit_used < 3'(OUTQ_DEPTH));
    assign accept        = s_axis_tvalid && s_axis_tready;

    // line parser, issues counter increments and reads
    lsch_parse #(
        .CODE_LIMIT (CODE_LIMIT)
    ) u_parse (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .action     (s_axis_tuser),
        .byte_value (s_axis_tdata[BYTE_BITS-1:0]),
        .query_code (s_axis_tdata[BYTE_BITS+CODE_BITS-1:BYTE_BITS]),
        .op         (op)
    );

    // counter ram with read-modify-write
    lsch_update #(
        .CODE_LIMIT (CODE_LIMIT),
        .COUNT_BITS (COUNT_BITS)
    ) u_update (
        .clk       (clk),
        .rst_n     (rst_n),
        .op        (op),
        .clearing  (clearing),
        .read_pend (read_pend),
        .res       (res)
    );

    // result words wait here for the output side
    lsch_outq u_outq (
        .clk        (clk),
        .rst_n      (rst_n),
        .res        (res),
        .pop        (m_axis_tready),
        .head_valid (m_axis_tvalid),
        .head_code  (head_code),
        .head_occ   (head_occ),
        .count      (q_count)
    );

    assign m_axis_tdata = {(M_DATA_BITS - CODE_BITS - OCC_BITS)'(0), head_occ, head_code};

endmodule

// ===== sv/lsch_checker.sv =====
// ----------------------------------------------------------------------------
// lsch_checker
// port level checks of the status code histogram
// ----------------------------------------------------------------------------
`include "log_status_code_histogram_defines.svh"

module lsch_checker
    import lsch_pkg::*;
#(
    parameter int CODE_LIMIT = CODE_LIMIT_DEF
) (
    input logic                   clk,
    input logic                   rst_n,
    input logic                   s_axis_tvalid,
    input logic                   s_axis_tready,
    input logic [ACT_BITS-1:0]    s_axis_tuser,
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready,
    input logic [M_DATA_BITS-1:0] m_axis_tdata
);

    logic                 read_accept;
    logic                 stalled;
    logic                 out_valid;
    logic [CODE_BITS-1:0] out_code;
    logic [OCC_BITS-1:0]  out_occ;
    logic                 code_ok;
    logic                 count_seen;

    assign read_accept = s_axis_tvalid && s_axis_tready && (s_axis_tuser == ACT_READ);
    assign out_valid   = m_axis_tvalid;
    assign stalled     = out_valid && !m_axis_tready;
    assign out_code    = m_axis_tdata[CODE_BITS-1:0];
    assign out_occ     = m_axis_tdata[CODE_BITS +: OCC_BITS];
    assign code_ok     = (out_code >= CODE_BITS'(LOW_CODE)) &&
                         (out_code < CODE_BITS'(CODE_LIMIT));
    assign count_seen  = out_valid && (out_occ != '0);

    // handshake rules on the output
    `LSCH_ASSERT(a_out_hold, stalled |=> m_axis_tvalid, "output word dropped while stalled")
    `LSCH_ASSERT(a_out_stable, stalled |=> $stable(m_axis_tdata), "stalled output word changed")

    // a nonzero count only for a code inside the histogram
    `LSCH_ASSERT_IMP(a_count_range, count_seen, code_ok, "count for a code outside the histogram")

    // an empty queue fills only from an accepted read, through the update stage and the queue register
    `LSCH_ASSERT_IMP(a_read_latency, $rose(out_valid), $past(read_accept, 2), "orphan result word")

endmodule

bind log_status_code_histogram lsch_checker #(
    .CODE_LIMIT (CODE_LIMIT)
) u_lsch_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
